@@ hw/rtl/scsm_pkg.sv @@
// Shared types, constants and register map of the shadow call stack monitor.
package scsm_pkg;

    localparam int DEF_STACK_DEPTH = 32;
    localparam int DEF_ADDR_WIDTH  = 32;

    localparam int FUNC_W   = 32;
    localparam int FRAME_W  = 32;
    localparam int STAT_W   = 2;
    localparam int DEPTH_W  = 6;
    localparam int MISS_W   = 16;
    localparam int LW_W     = 32;
    localparam int LIMIT_W  = 32;
    localparam int MARGIN_W = 16;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_GUARD_EN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN   = 2'd2;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd1024;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_GUARD    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_UNBAL    = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

@@ hw/rtl/scsm_if.sv @@
// Valid/ready channel interfaces for event words and result words.
interface scsm_in_if;
    import scsm_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [FUNC_W-1:0]  func_addr;
    logic [FRAME_W-1:0] frame_ptr;

    modport source (output valid, output mode, output func_addr, output frame_ptr,
                    input ready);
    modport sink (input valid, input mode, input func_addr, input frame_ptr,
                  output ready);
endinterface

interface scsm_out_if;
    import scsm_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [DEPTH_W-1:0] depth;
    logic [MISS_W-1:0]  missed_count;
    logic [LW_W-1:0]    low_water;

    modport source (output valid, output status, output depth, output missed_count,
                    output low_water, input ready);
    modport sink (input valid, input status, input depth, input missed_count,
                  input low_water, output ready);
endinterface

@@ hw/rtl/scsm_cell.sv @@
// One entry of the shifting shadow stack, loading from its upper or lower neighbor.
module scsm_cell #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  scsm_pkg::t_shift_ctl  i_ctl,
    input  logic [W-1:0]          i_from_up,
    input  logic [W-1:0]          i_from_down,
    output logic [W-1:0]          o_q
);
    import scsm_pkg::*;

    logic [W-1:0] r_q;
    logic [W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_from_up;
        end else if (i_ctl.pop) begin
            n_q = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/shadow_call_stack_monitor_unit.sv @@
// Top level of the shadow call stack monitor: control, guard check and the cell row.
//
// The monitor takes one entry or exit event word per clock and returns one result
// word for each, in the cycle after acceptance; with the result side always ready it
// sustains one event per cycle. Each event is resolved in the cycle it is accepted:
// the return addresses sit in a row of STACK_DEPTH cells that shifts down on a push
// and up on a pop, so the top of stack is always in the first cell and the address
// check needs no memory read. A single result register holds the answer; a new
// event is taken in the same cycle the held result is taken. Status reports guard
// violations, return mismatches and unbalanced exits without stopping the monitor.
// The depth output is the occupancy modulo 64, and low_water only moves while the
// guard is enabled. Registers (guard_enable at 0x0, stack_limit at 0x4,
// guard_margin at 0x8) should be written only while no event is in flight.
module shadow_call_stack_monitor_unit #(
    parameter int STACK_DEPTH = scsm_pkg::DEF_STACK_DEPTH,
    parameter int ADDR_WIDTH  = scsm_pkg::DEF_ADDR_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scsm_pkg::APB_AW-1:0] paddr,
    input  logic [scsm_pkg::APB_DW-1:0] pwdata,
    output logic [scsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    scsm_in_if.sink                     i_in,
    scsm_out_if.source                  o_out
);
    import scsm_pkg::*;

    localparam int EW = (ADDR_WIDTH < FUNC_W) ? ADDR_WIDTH : FUNC_W;
    localparam int OW = $clog2(STACK_DEPTH + 1);

    logic                r_gen;
    logic [LIMIT_W-1:0]  r_limit;
    logic [MARGIN_W-1:0] r_margin;

    logic [OW-1:0]       r_occ;
    logic [OW-1:0]       n_occ;
    logic [MISS_W-1:0]   r_miss;
    logic [MISS_W-1:0]   n_miss;
    logic [EW-1:0]       r_lw;
    logic [EW-1:0]       n_lw;
    t_status             r_status;
    t_status             n_status;
    logic                r_ovalid;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic [REG_IDX_W-1:0]  w_reg_idx;
    logic [EW-1:0]         w_fn;
    logic [EW-1:0]         w_frame;
    logic [ADDR_WIDTH-1:0] w_dist;
    logic                  w_guard_bad;
    logic                  w_full;
    t_shift_ctl            w_ctl;
    logic [EW-1:0]         w_cell_q [STACK_DEPTH];
    logic [OW+5:0]         w_occ_ext;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            REG_GUARD_EN: prdata = APB_DW'(r_gen);
            REG_LIMIT:    prdata = APB_DW'(r_limit);
            REG_MARGIN:   prdata = APB_DW'(r_margin);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= 1'b0;
            r_limit  <= '0;
            r_margin <= MARGIN_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GUARD_EN: r_gen    <= pwdata[0];
                REG_LIMIT:    r_limit  <= pwdata[LIMIT_W-1:0];
                REG_MARGIN:   r_margin <= pwdata[MARGIN_W-1:0];
                default:      ;
            endcase
        end
    end

    assign i_in.ready = !r_ovalid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_fn    = i_in.func_addr[EW-1:0];
    assign w_frame = i_in.frame_ptr[EW-1:0];
    assign w_full  = (r_occ == OW'(STACK_DEPTH));

    assign w_dist      = ADDR_WIDTH'(w_frame) - ADDR_WIDTH'(r_limit);
    assign w_guard_bad = w_dist[ADDR_WIDTH-1] || (w_dist < ADDR_WIDTH'(r_margin));

    always_comb begin
        n_occ    = r_occ;
        n_miss   = r_miss;
        n_lw     = r_lw;
        n_status = ST_OK;
        w_ctl    = '0;
        if (!i_in.mode) begin
            if (r_gen) begin
                if (w_frame < r_lw) begin
                    n_lw = w_frame;
                end
                if (w_guard_bad) begin
                    n_status = ST_GUARD;
                end
            end
            if (!w_full) begin
                w_ctl.push = 1'b1;
                n_occ      = r_occ + OW'(1);
            end else begin
                n_miss = r_miss + MISS_W'(1);
            end
        end else begin
            if (r_miss != '0) begin
                n_miss = r_miss - MISS_W'(1);
            end else if (r_occ != '0) begin
                if (w_cell_q[0] != w_fn) begin
                    n_status = ST_MISMATCH;
                end else begin
                    w_ctl.pop = 1'b1;
                    n_occ     = r_occ - OW'(1);
                end
            end else begin
                n_status = ST_UNBAL;
            end
        end
        if (!w_accept) begin
            w_ctl = '0;
        end
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [EW-1:0] w_up;
        logic [EW-1:0] w_down;
        if (i == 0) begin : g_first
            assign w_up = w_fn;
        end else begin : g_rest
            assign w_up = w_cell_q[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_last
            assign w_down = w_cell_q[i];
        end else begin : g_inner
            assign w_down = w_cell_q[i+1];
        end
        scsm_cell #(
            .W (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_q         (w_cell_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_miss   <= '0;
            r_lw     <= '1;
            r_ovalid <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (w_accept) begin
                r_occ    <= n_occ;
                r_miss   <= n_miss;
                r_lw     <= n_lw;
                r_status <= n_status;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign w_occ_ext          = {6'b0, r_occ};
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_status;
    assign o_out.depth        = w_occ_ext[DEPTH_W-1:0];
    assign o_out.missed_count = r_miss;
    assign o_out.low_water    = LW_W'(r_lw);

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(STACK_DEPTH))
        else $error("Shadow stack occupancy exceeds its depth.");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.push && w_ctl.pop))
        else $error("Cell row asked to push and pop at once.");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> (r_occ == $past(r_occ) - OW'(1)))
        else $error("Pop did not lower the occupancy by one.");

    a_miss_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode && (r_miss != '0)) |-> !w_ctl.pop)
        else $error("Exit popped the stack while misses were pending.");

    a_lw_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_lw <= $past(r_lw)))
        else $error("Low-water mark rose without a reset.");

endmodule
